// File: rtl/core/kea_pkg.sv
// Shared types, constants and arithmetic helpers for the kinetic energy tensor accumulator.
package kea_pkg;

    localparam int VEL_BITS   = 16;
    localparam int MASS_BITS  = 16;
    localparam int SUM_BITS   = VEL_BITS + 1;
    localparam int MAG_BITS   = SUM_BITS;
    localparam int PROD_BITS  = 2 * MAG_BITS;
    localparam int WGT_BITS   = PROD_BITS + MASS_BITS;
    localparam int ACC_BITS   = 64;
    localparam int SCALE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FULL_BITS  = ACC_BITS + SCALE_BITS;
    localparam int NUM_TERMS  = 6;
    localparam int TERM_IDX_BITS = $clog2(NUM_TERMS);
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd65536;
    localparam logic [63:0] ROUND_HALF = 64'd32768;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Tensor term slots
    localparam logic [TERM_IDX_BITS-1:0] T_XX = 3'd0;
    localparam logic [TERM_IDX_BITS-1:0] T_YX = 3'd1;
    localparam logic [TERM_IDX_BITS-1:0] T_YY = 3'd2;
    localparam logic [TERM_IDX_BITS-1:0] T_ZX = 3'd3;
    localparam logic [TERM_IDX_BITS-1:0] T_ZY = 3'd4;
    localparam logic [TERM_IDX_BITS-1:0] T_ZZ = 3'd5;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef struct packed {
        logic                        box_id;
        logic [MASS_BITS-1:0]        mass;
        logic signed [VEL_BITS-1:0]  vel_now_x;
        logic signed [VEL_BITS-1:0]  vel_now_y;
        logic signed [VEL_BITS-1:0]  vel_now_z;
        logic signed [VEL_BITS-1:0]  vel_half_x;
        logic signed [VEL_BITS-1:0]  vel_half_y;
        logic signed [VEL_BITS-1:0]  vel_half_z;
        logic                        last_particle;
    } kea_in_t;

    typedef struct packed {
        logic                        result_box;
        logic signed [ACC_BITS-1:0]  tensor_xx;
        logic signed [ACC_BITS-1:0]  tensor_yx;
        logic signed [ACC_BITS-1:0]  tensor_yy;
        logic signed [ACC_BITS-1:0]  tensor_zx;
        logic signed [ACC_BITS-1:0]  tensor_zy;
        logic signed [ACC_BITS-1:0]  tensor_zz;
        logic signed [ACC_BITS-1:0]  kinetic_trace;
    } kea_out_t;

    // Classified particle as it sits in the queue
    typedef struct packed {
        logic                        box;
        logic                        last;
        logic [MASS_BITS-1:0]        mass;
        logic signed [SUM_BITS-1:0]  sum_x;
        logic signed [SUM_BITS-1:0]  sum_y;
        logic signed [SUM_BITS-1:0]  sum_z;
    } kea_entry_t;

    // Final sums of one box handed to the scaler
    typedef struct packed {
        logic                                box;
        logic [NUM_TERMS-1:0][ACC_BITS-1:0]  sums;
    } kea_snap_t;

    typedef enum logic [3:0] {
        SCL_IDLE,
        SCL_MAG,
        SCL_MUL_LO,
        SCL_MUL_HI,
        SCL_SUM,
        SCL_SAT,
        SCL_TRACE_A,
        SCL_TRACE_B,
        SCL_OUT
    } kea_scl_state_t;

    // First and second axis of each tensor term
    function automatic logic [1:0] lane_a(input int k);
        logic [1:0] r;
        unique case (k)
            0:       r = AX_X;
            1, 2:    r = AX_Y;
            default: r = AX_Z;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] lane_b(input int k);
        logic [1:0] r;
        unique case (k)
            0, 1, 3: r = AX_X;
            2, 4:    r = AX_Y;
            default: r = AX_Z;
        endcase
        return r;
    endfunction

    // Signed 64-bit add that clamps at the limits
    function automatic logic signed [ACC_BITS-1:0] sat_add64(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS:0] s;
        logic signed [ACC_BITS-1:0] r;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1])
        begin
            r = s[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r = s[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/kea_queue.sv
// Small register FIFO between the front and back parts.
module kea_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/kea_front.sv
// Front part: accepts particles, forms per-axis velocity sums and clamps the box number.
module kea_front #(
    parameter int NUM_BOXES = 2
) (
    input  logic                in_valid,
    output logic                in_ready,
    input  kea_pkg::kea_in_t    in_data,
    input  logic                q_full,
    output logic                q_push,
    output kea_pkg::kea_entry_t q_data
);
    import kea_pkg::*;

    localparam logic [4:0] BOX_LIMIT = 5'(NUM_BOXES);
    localparam logic       BOX_TOP   = 1'(NUM_BOXES - 1);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the item
    always_comb
    begin
        q_data.last  = in_data.last_particle;
        q_data.mass  = in_data.mass;
        q_data.box   = ({4'b0, in_data.box_id} >= BOX_LIMIT) ? BOX_TOP : in_data.box_id;
        q_data.sum_x = SUM_BITS'(in_data.vel_now_x) + SUM_BITS'(in_data.vel_half_x);
        q_data.sum_y = SUM_BITS'(in_data.vel_now_y) + SUM_BITS'(in_data.vel_half_y);
        q_data.sum_z = SUM_BITS'(in_data.vel_now_z) + SUM_BITS'(in_data.vel_half_z);
    end

endmodule

// File: rtl/core/kea_back.sv
// Back part: six product lanes feeding the saturating tensor accumulators.
module kea_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  kea_pkg::kea_entry_t q_data,
    output logic                q_pop,
    output logic                snap_valid,
    input  logic                snap_ready,
    output kea_pkg::kea_snap_t  snap
);
    import kea_pkg::*;

    logic                   a_valid_reg;
    logic                   a_last_reg;
    logic                   a_box_reg;
    logic [MASS_BITS-1:0]   a_mass_reg;
    logic [NUM_TERMS-1:0]   a_neg_reg;
    logic [PROD_BITS-1:0]   a_prod_reg [NUM_TERMS];

    logic                   b_valid_reg;
    logic                   b_last_reg;
    logic                   b_box_reg;
    logic [NUM_TERMS-1:0]   b_neg_reg;
    logic [WGT_BITS-1:0]    b_wgt_reg [NUM_TERMS];

    logic signed [ACC_BITS-1:0] sum_reg  [NUM_TERMS];
    logic signed [ACC_BITS-1:0] sum_next [NUM_TERMS];

    logic [MAG_BITS-1:0]    mag   [3];
    logic [2:0]             sgn;
    logic [NUM_TERMS-1:0]   neg_new;
    logic [PROD_BITS-1:0]   prod_new [NUM_TERMS];
    logic [WGT_BITS-1:0]    wgt_new  [NUM_TERMS];
    logic signed [ACC_BITS-1:0] acc_sum [NUM_TERMS];
    logic                   adv;

    // Hold the whole lane pipeline while a finished box waits for the scaler
    assign snap_valid = b_valid_reg && b_last_reg;
    assign adv        = !(snap_valid && !snap_ready);
    assign q_pop      = q_valid && adv;

    // Magnitudes and signs of the velocity sums
    always_comb
    begin
        sgn[AX_X] = q_data.sum_x[SUM_BITS-1];
        sgn[AX_Y] = q_data.sum_y[SUM_BITS-1];
        sgn[AX_Z] = q_data.sum_z[SUM_BITS-1];
        mag[AX_X] = sgn[AX_X] ? MAG_BITS'(-q_data.sum_x) : MAG_BITS'(q_data.sum_x);
        mag[AX_Y] = sgn[AX_Y] ? MAG_BITS'(-q_data.sum_y) : MAG_BITS'(q_data.sum_y);
        mag[AX_Z] = sgn[AX_Z] ? MAG_BITS'(-q_data.sum_z) : MAG_BITS'(q_data.sum_z);
    end

    // Lane products: velocity pair, then weight by mass
    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            neg_new[k]  = sgn[lane_a(k)] ^ sgn[lane_b(k)];
            prod_new[k] = PROD_BITS'(mag[lane_a(k)]) * PROD_BITS'(mag[lane_b(k)]);
            wgt_new[k]  = WGT_BITS'(a_prod_reg[k]) * WGT_BITS'(a_mass_reg);
        end
    end

    // Saturating accumulation; clear after the last particle of a box
    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            acc_sum[k]  = sat_add64(sum_reg[k],
                b_neg_reg[k] ? -$signed(ACC_BITS'(b_wgt_reg[k]))
                             :  $signed(ACC_BITS'(b_wgt_reg[k])));
            sum_next[k] = sum_reg[k];
            if (adv && b_valid_reg)
            begin
                sum_next[k] = b_last_reg ? '0 : acc_sum[k];
            end
            snap.sums[k] = acc_sum[k];
        end
        snap.box = b_box_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg <= q_valid;
                b_valid_reg <= a_valid_reg;
            end
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    // Advance lane payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_last_reg <= q_data.last;
            a_box_reg  <= q_data.box;
            a_mass_reg <= q_data.mass;
            a_neg_reg  <= neg_new;
            b_last_reg <= a_last_reg;
            b_box_reg  <= a_box_reg;
            b_neg_reg  <= a_neg_reg;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                a_prod_reg[k] <= prod_new[k];
                b_wgt_reg[k]  <= wgt_new[k];
            end
        end
    end

endmodule

// File: rtl/core/kea_scaler.sv
// Scaler: applies the Q16 energy scale to each sum with one shared 32x32 multiplier.
module kea_scaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kea_pkg::SCALE_BITS-1:0] energy_scale,
    input  logic                          snap_valid,
    output logic                          snap_ready,
    input  kea_pkg::kea_snap_t            snap,
    output logic                          out_valid,
    input  logic                          out_ready,
    output kea_pkg::kea_out_t             out_data
);
    import kea_pkg::*;

    localparam logic [TERM_IDX_BITS-1:0] TERM_LAST = TERM_IDX_BITS'(NUM_TERMS - 1);

    kea_scl_state_t state_reg, state_next;

    logic [TERM_IDX_BITS-1:0]   idx_reg;
    logic                       box_reg;
    logic [ACC_BITS-1:0]        sums_reg [NUM_TERMS];
    logic signed [ACC_BITS-1:0] term_reg [NUM_TERMS];
    logic                       neg_reg;
    logic [ACC_BITS-1:0]        mag_reg;
    logic [63:0]                plo_reg;
    logic [63:0]                phi_reg;
    logic [FULL_BITS-1:0]       full_reg;
    logic signed [ACC_BITS-1:0] trace_reg;
    logic                       out_valid_reg;
    kea_out_t                   out_data_reg;

    logic [ACC_BITS-1:0]        sel_sum;
    logic [FULL_BITS-FRAC_BITS-1:0] quot;
    logic signed [ACC_BITS-1:0] sat_term;
    logic                       take_snap;
    logic                       load_out;
    logic [31:0]                mul_a;
    logic [63:0]                mul_p;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign sel_sum   = sums_reg[idx_reg];
    assign quot      = full_reg[FULL_BITS-1:FRAC_BITS];

    // Pick the low or high half of the magnitude for the multiplier
    assign mul_a = (state_reg == SCL_MUL_LO) ? mag_reg[31:0] : mag_reg[63:32];
    assign mul_p = {32'b0, mul_a} * {32'b0, energy_scale};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SCL_IDLE:    state_next = snap_valid ? SCL_MAG : SCL_IDLE;
            SCL_MAG:     state_next = SCL_MUL_LO;
            SCL_MUL_LO:  state_next = SCL_MUL_HI;
            SCL_MUL_HI:  state_next = SCL_SUM;
            SCL_SUM:     state_next = SCL_SAT;
            SCL_SAT:     state_next = (idx_reg == TERM_LAST) ? SCL_TRACE_A : SCL_MAG;
            SCL_TRACE_A: state_next = SCL_TRACE_B;
            SCL_TRACE_B: state_next = SCL_OUT;
            SCL_OUT:     state_next = load_out ? SCL_IDLE : SCL_OUT;
            default:     state_next = SCL_IDLE;
        endcase
    end

    // Control strobes
    always_comb
    begin
        snap_ready = (state_reg == SCL_IDLE);
        take_snap  = snap_ready && snap_valid;
        load_out   = (state_reg == SCL_OUT) && (!out_valid_reg || out_ready);
    end

    // Round-shifted magnitude back to a signed, saturated term
    always_comb
    begin
        if (neg_reg)
        begin
            if ((quot[FULL_BITS-FRAC_BITS-1:ACC_BITS] != '0) ||
                (quot[ACC_BITS-1] && (quot[ACC_BITS-2:0] != '0)))
            begin
                sat_term = ACC_MIN;
            end
            else
            begin
                sat_term = -$signed(quot[ACC_BITS-1:0]);
            end
        end
        else
        begin
            if (quot[FULL_BITS-FRAC_BITS-1:ACC_BITS-1] != '0)
            begin
                sat_term = ACC_MAX;
            end
            else
            begin
                sat_term = $signed(quot[ACC_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: one term at a time through the shared multiplier
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SCL_IDLE:
            begin
                idx_reg <= '0;
                if (take_snap)
                begin
                    box_reg <= snap.box;
                    for (int k = 0; k < NUM_TERMS; k++)
                    begin
                        sums_reg[k] <= snap.sums[k];
                    end
                end
            end
            SCL_MAG:
            begin
                neg_reg <= sel_sum[ACC_BITS-1];
                mag_reg <= sel_sum[ACC_BITS-1] ? -sel_sum : sel_sum;
            end
            SCL_MUL_LO:
            begin
                plo_reg <= mul_p + ROUND_HALF;
            end
            SCL_MUL_HI:
            begin
                phi_reg <= mul_p;
            end
            SCL_SUM:
            begin
                full_reg <= {phi_reg, 32'b0} + {32'b0, plo_reg};
            end
            SCL_SAT:
            begin
                term_reg[idx_reg] <= sat_term;
                idx_reg           <= idx_reg + 1'b1;
            end
            SCL_TRACE_A:
            begin
                trace_reg <= sat_add64(term_reg[T_XX], term_reg[T_YY]);
            end
            SCL_TRACE_B:
            begin
                trace_reg <= sat_add64(trace_reg, term_reg[T_ZZ]);
            end
            SCL_OUT:
            begin
                if (load_out)
                begin
                    out_data_reg.result_box    <= box_reg;
                    out_data_reg.tensor_xx     <= term_reg[T_XX];
                    out_data_reg.tensor_yx     <= term_reg[T_YX];
                    out_data_reg.tensor_yy     <= term_reg[T_YY];
                    out_data_reg.tensor_zx     <= term_reg[T_ZX];
                    out_data_reg.tensor_zy     <= term_reg[T_ZY];
                    out_data_reg.tensor_zz     <= term_reg[T_ZZ];
                    out_data_reg.kinetic_trace <= trace_reg;
                end
            end
            default:
            begin
                idx_reg <= '0;
            end
        endcase
    end

endmodule

// File: rtl/core/kinetic_energy_tensor_accumulator.sv
// Top level of the kinetic energy tensor accumulator.
// Particles are taken at one per cycle into a four-entry queue while it has room, and six
// parallel product lanes (velocity pair multiply, then mass multiply, then a saturating 64-bit
// add) retire one particle per cycle into the tensor accumulators, except while a finished box
// waits for the scaler. The particle marked last hands the six sums to the scaler, which runs
// each through one shared 32x32 multiplier in five steps, then forms the trace. The next box
// accumulates meanwhile; a second last particle that arrives before the scaler is free holds
// the lanes until it is taken. energy_scale may be written at any idle time and takes effect
// for the next result.
module kinetic_energy_tensor_accumulator #(
    parameter int NUM_BOXES = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kea_pkg::kea_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kea_pkg::kea_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [kea_pkg::SCALE_BITS-1:0] cfg_wdata
);
    import kea_pkg::*;

    localparam int ENTRY_BITS = $bits(kea_entry_t);

    logic [SCALE_BITS-1:0] energy_scale_reg;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    kea_entry_t            q_wr_data;
    kea_entry_t            q_rd_data;
    logic                  snap_valid;
    logic                  snap_ready;
    kea_snap_t             snap;

    // Hold the scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            energy_scale_reg <= cfg_wdata;
        end
    end

    kea_front #(
        .NUM_BOXES (NUM_BOXES)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    kea_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    kea_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (!q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    kea_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_scale (energy_scale_reg),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // A finished box stays offered until the scaler takes it
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !snap_ready |=> snap_valid)
        else $error("finished box dropped before the scaler took it");

    // The scaler is busy right after taking a box
    a_snap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && snap_ready |=> !snap_ready)
        else $error("scaler ready again right after taking a box");

    // An accepted item is in the queue on the next cycle
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !q_empty)
        else $error("accepted item missing from the queue");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the kinetic energy tensor accumulator.
`timescale 1ns / 1ps

module tb;
    import kea_pkg::*;

    localparam int LATENCY       = 48;
    localparam int IDLE_PCT      = 38;
    localparam int BULK_ITEMS    = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 86;
    localparam logic [SCALE_BITS-1:0] SCALE_EIGHTH = 32'd8192;
    localparam logic [SCALE_BITS-1:0] SCALE_FULL   = 32'hFFFF_FFFF;
    localparam logic [SCALE_BITS-1:0] SCALE_ZERO   = 32'd0;
    localparam logic [SCALE_BITS-1:0] SCALE_LSB    = 32'd1;

    typedef struct {
        logic [SCALE_BITS-1:0] scale;
        kea_in_t               item;
        bit                    typed;
        kea_out_t              result;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    kea_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    kea_out_t              out_data;
    logic                  cfg_we;
    logic [SCALE_BITS-1:0] cfg_wdata;

    // Predictor state: six tensor accumulators and the scale register copy
    logic signed [ACC_BITS-1:0] acc_xx, acc_yx, acc_yy, acc_zx, acc_zy, acc_zz;
    logic [SCALE_BITS-1:0]      scale_q16;

    kea_out_t  pending_tensors[$];
    stim_row_t directed_rows[$];
    int        mismatches;
    bit        calm;

    kinetic_energy_tensor_accumulator #(
        .NUM_BOXES(2)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Generate a 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Add two signed 64-bit values, clamping at the limits
    function automatic logic signed [ACC_BITS-1:0] clamp_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS:0] s;
        s = a + b;
        if (s > ACC_MAX)
            return ACC_MAX;
        if (s < ACC_MIN)
            return ACC_MIN;
        return s[ACC_BITS-1:0];
    endfunction

    // Mass-weighted velocity product; at most about 2^48, so always exact
    function automatic logic signed [ACC_BITS-1:0] particle_weight(
        input logic [MASS_BITS-1:0]      m,
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [SUM_BITS-1:0] b
    );
        logic signed [ACC_BITS-1:0] wa, wb, wm;
        wa = a;
        wb = b;
        wm = m;
        return wa * wb * wm;
    endfunction

    // Apply the Q16 scale, round half away from zero, saturate to 64 bits
    function automatic logic signed [ACC_BITS-1:0] scale_term(
        input logic signed [ACC_BITS-1:0] s
    );
        logic [127:0]               mag, prod;
        logic                       neg;
        logic signed [ACC_BITS-1:0] low;
        neg  = s[ACC_BITS-1];
        mag  = {64'd0, (neg ? -s : s)};
        prod = (mag * {96'd0, scale_q16} + 128'd32768) >> FRAC_BITS;
        if (prod[127:63] != '0)
            return neg ? ACC_MIN : ACC_MAX;
        low = prod[63:0];
        return neg ? -low : low;
    endfunction

    // Accumulate one particle; on the last one of a box, form the tensor and clear
    function automatic bit absorb_particle(input kea_in_t p, output kea_out_t r);
        logic signed [SUM_BITS-1:0] sx, sy, sz;
        logic signed [ACC_BITS-1:0] txx, tyy, tzz;
        sx = p.vel_now_x + p.vel_half_x;
        sy = p.vel_now_y + p.vel_half_y;
        sz = p.vel_now_z + p.vel_half_z;
        acc_xx = clamp_add(acc_xx, particle_weight(p.mass, sx, sx));
        acc_yx = clamp_add(acc_yx, particle_weight(p.mass, sy, sx));
        acc_yy = clamp_add(acc_yy, particle_weight(p.mass, sy, sy));
        acc_zx = clamp_add(acc_zx, particle_weight(p.mass, sz, sx));
        acc_zy = clamp_add(acc_zy, particle_weight(p.mass, sz, sy));
        acc_zz = clamp_add(acc_zz, particle_weight(p.mass, sz, sz));
        r = '0;
        if (!p.last_particle)
            return 1'b0;
        txx             = scale_term(acc_xx);
        tyy             = scale_term(acc_yy);
        tzz             = scale_term(acc_zz);
        r.result_box    = p.box_id;
        r.tensor_xx     = txx;
        r.tensor_yx     = scale_term(acc_yx);
        r.tensor_yy     = tyy;
        r.tensor_zx     = scale_term(acc_zx);
        r.tensor_zy     = scale_term(acc_zy);
        r.tensor_zz     = tzz;
        r.kinetic_trace = clamp_add(clamp_add(txx, tyy), tzz);
        acc_xx = '0;
        acc_yx = '0;
        acc_yy = '0;
        acc_zx = '0;
        acc_zy = '0;
        acc_zz = '0;
        return 1'b1;
    endfunction

    function automatic kea_in_t particle(
        input logic                      box,
        input logic [MASS_BITS-1:0]      m,
        input logic signed [VEL_BITS-1:0] nx,
        input logic signed [VEL_BITS-1:0] ny,
        input logic signed [VEL_BITS-1:0] nz,
        input logic signed [VEL_BITS-1:0] hx,
        input logic signed [VEL_BITS-1:0] hy,
        input logic signed [VEL_BITS-1:0] hz,
        input logic                      last
    );
        kea_in_t p;
        p.box_id        = box;
        p.mass          = m;
        p.vel_now_x     = nx;
        p.vel_now_y     = ny;
        p.vel_now_z     = nz;
        p.vel_half_x    = hx;
        p.vel_half_y    = hy;
        p.vel_half_z    = hz;
        p.last_particle = last;
        return p;
    endfunction

    function automatic kea_out_t tensor(
        input logic                      box,
        input logic signed [ACC_BITS-1:0] xx,
        input logic signed [ACC_BITS-1:0] yx,
        input logic signed [ACC_BITS-1:0] yy,
        input logic signed [ACC_BITS-1:0] zx,
        input logic signed [ACC_BITS-1:0] zy,
        input logic signed [ACC_BITS-1:0] zz,
        input logic signed [ACC_BITS-1:0] tr
    );
        kea_out_t r;
        r.result_box    = box;
        r.tensor_xx     = xx;
        r.tensor_yx     = yx;
        r.tensor_yy     = yy;
        r.tensor_zx     = zx;
        r.tensor_zy     = zy;
        r.tensor_zz     = zz;
        r.kinetic_trace = tr;
        return r;
    endfunction

    // Velocity component biased toward the extremes and small values
    function automatic logic signed [VEL_BITS-1:0] rand_vel();
        logic signed [VEL_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = '0;
            3:       v = VEL_BITS'($urandom_range(0, 16) - 8);
            default: v = VEL_BITS'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [MASS_BITS-1:0] rand_mass();
        logic [MASS_BITS-1:0] m;
        case ($urandom_range(0, 9))
            0:       m = '0;
            1:       m = '1;
            default: m = MASS_BITS'($urandom);
        endcase
        return m;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_field(
        input string               name,
        input logic [ACC_BITS-1:0] got,
        input logic [ACC_BITS-1:0] want
    );
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name,
                                      $signed(got), $signed(want)));
    endtask

    // Write the scale register; only called while the block is idle
    task automatic write_scale(input logic [SCALE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scale_q16 = value;
    endtask

    // Drop valid, wait for every pending tensor, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_tensors.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Offer one particle after a random gap and hold it until accepted
    task automatic send_particle(
        input kea_in_t  p,
        input bit       typed,
        input kea_out_t typed_result
    );
        int       gap;
        kea_out_t r;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (absorb_particle(p, r))
            pending_tensors.push_back(typed ? typed_result : r);
    endtask

    // Stall the result side at random and check each accepted tensor
    always @(posedge clk)
    begin : check_results
        kea_out_t want;
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tensors.size() == 0)
            begin
                report_mismatch("tensor with none expected");
            end
            else
            begin
                want = pending_tensors.pop_front();
                compare_field("result_box", {63'd0, out_data.result_box},
                              {63'd0, want.result_box});
                compare_field("tensor_xx", out_data.tensor_xx, want.tensor_xx);
                compare_field("tensor_yx", out_data.tensor_yx, want.tensor_yx);
                compare_field("tensor_yy", out_data.tensor_yy, want.tensor_yy);
                compare_field("tensor_zx", out_data.tensor_zx, want.tensor_zx);
                compare_field("tensor_zy", out_data.tensor_zy, want.tensor_zy);
                compare_field("tensor_zz", out_data.tensor_zz, want.tensor_zz);
                compare_field("kinetic_trace", out_data.kinetic_trace,
                              want.kinetic_trace);
            end
        end
    end

    // Stimulus: directed table, a long box of maximal particles, then random phases
    initial
    begin
        kea_out_t              none;
        int                    left;
        logic [SCALE_BITS-1:0] phase_scale;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        mismatches = 0;
        calm       = 1'b0;
        scale_q16  = SCALE_RESET;
        acc_xx = '0;
        acc_yx = '0;
        acc_yy = '0;
        acc_zx = '0;
        acc_zy = '0;
        acc_zz = '0;
        none   = '0;
        left   = 0;

        // Reset value of the scale: zero particle, unit particle and extreme velocities
        directed_rows.push_back('{SCALE_RESET, particle(0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                                  tensor(0, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{SCALE_RESET, particle(1, 1, 1, 0, 0, 0, 0, 0, 1), 1,
                                  tensor(1, 1, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{SCALE_RESET, particle(0, 16'hFFFF, 32767, 32767, 32767,
                                  32767, 32767, 32767, 0), 0, none});
        directed_rows.push_back('{SCALE_RESET, particle(1, 16'hFFFF, -32768, -32768, -32768,
                                  -32768, -32768, -32768, 1), 0, none});
        directed_rows.push_back('{SCALE_RESET, particle(1, 16'h8001, 32767, -32768, 5,
                                  -32768, 32767, -5, 1), 0, none});
        directed_rows.push_back('{SCALE_RESET, particle(0, 16'hA5A5, 32767, -32768, 1000,
                                  32767, -32768, -3000, 1), 0, none});
        // Full scale: at full mass every term saturates, with sign; then zero mass and a small particle
        directed_rows.push_back('{SCALE_FULL, particle(0, 16'hFFFF, -32768, 32767, -32768,
                                  -32768, 32767, -32768, 1), 1,
                                  tensor(0, ACC_MAX, ACC_MIN, ACC_MAX, ACC_MAX, ACC_MIN,
                                         ACC_MAX, ACC_MAX)});
        directed_rows.push_back('{SCALE_FULL, particle(1, 0, 32767, -32768, 32767,
                                  32767, -32768, 32767, 1), 1,
                                  tensor(1, 0, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{SCALE_FULL, particle(1, 1, 1, 0, 0, 0, -1, 0, 1), 0, none});
        // Zero scale wipes out the largest sums
        directed_rows.push_back('{SCALE_ZERO, particle(0, 16'hFFFF, -32768, -32768, -32768,
                                  -32768, -32768, -32768, 1), 1,
                                  tensor(0, 0, 0, 0, 0, 0, 0, 0)});
        // Smallest scale: rounding of exact halves and just below
        directed_rows.push_back('{SCALE_LSB, particle(1, 16'h8000, 1, -1, 0, 0, 0, 0, 1), 0,
                                  none});
        directed_rows.push_back('{SCALE_LSB, particle(0, 16'h7FFF, 1, -1, 0, 0, 0, 0, 1), 0,
                                  none});
        directed_rows.push_back('{SCALE_LSB, particle(1, 16'hFFFF, -32768, -32768, 32767,
                                  -32768, -32768, 32767, 1), 0, none});
        // One-eighth scale: a four-particle box, box number taken from the last one
        directed_rows.push_back('{SCALE_EIGHTH, particle(0, 16'd300, 1200, -700, 42,
                                  15, -9000, 8, 0), 0, none});
        directed_rows.push_back('{SCALE_EIGHTH, particle(1, 16'd7, -5, 6, -7,
                                  30000, -31000, 2, 0), 0, none});
        directed_rows.push_back('{SCALE_EIGHTH, particle(1, 16'hFFFF, 0, 0, 0, -1, 1, -1, 0),
                                  0, none});
        directed_rows.push_back('{SCALE_EIGHTH, particle(0, 16'd4096, -32768, -1, 32767,
                                  32767, -1, -32768, 1), 0, none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table, rewriting the scale when a row asks for another one
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].scale != scale_q16)
            begin
                wait_drained();
                write_scale(directed_rows[i].scale);
            end
            send_particle(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
        end

        // Long box of maximal particles: the largest sums per particle pile up
        wait_drained();
        write_scale(SCALE_RESET);
        for (int n = 0; n < BULK_ITEMS; n++)
            send_particle(particle(n[0], 16'hFFFF, -32768, 32767, -32768,
                                   -32768, 32767, -32768, n == BULK_ITEMS - 1), 1'b0, none);

        // Random boxes under several scales, one phase without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       phase_scale = $urandom;
                1:       phase_scale = SCALE_FULL;
                2:       phase_scale = SCALE_EIGHTH;
                3:       phase_scale = SCALE_RESET;
                4:       phase_scale = $urandom_range(0, 262143);
                default: phase_scale = SCALE_LSB;
            endcase
            wait_drained();
            write_scale(phase_scale);
            calm <= (ph == 3);
            left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (left == 0)
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 8);
                left--;
                if (n == PHASE_ITEMS - 1)
                    left = 0;
                send_particle(particle($urandom_range(0, 1), rand_mass(), rand_vel(),
                                       rand_vel(), rand_vel(), rand_vel(), rand_vel(),
                                       rand_vel(), left == 0), 1'b0, none);
            end
        end
        calm <= 1'b0;

        // Drain and report
        wait_drained();
        if (mismatches == 0)
            $display("[kinetic_energy_tensor_accumulator] OK");
        else
            $display("[kinetic_energy_tensor_accumulator] ERROR");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("[kinetic_energy_tensor_accumulator] ERROR");
        $finish;
    end

endmodule
